// ===== rtl/gwm_pkg.sv =====
package gwm_pkg;

  // Number of pattern elements the cell row can hold.
  localparam int PATTERN_MAX = 64;

  // Width of the element count and of a cell index (holds PATTERN_MAX itself).
  localparam int CNT_W = $clog2(PATTERN_MAX + 1);

  // Special pattern characters.
  localparam logic [7:0] CHAR_STAR      = 8'h2A;
  localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

  // ASCII upper-case range and the offset to lower case.
  localparam logic [7:0] UPPER_FIRST = 8'h41;
  localparam logic [7:0] UPPER_LAST  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Input item opcodes.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PAT   = 2'd1,
    OP_DATA  = 2'd2,
    OP_END   = 2'd3
  } opcode_t;

  // Kind of one stored pattern element.
  typedef enum logic [1:0] {
    KIND_LIT  = 2'd0,
    KIND_ANY  = 2'd1,
    KIND_STAR = 2'd2
  } kind_t;

  // Control broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic             load_we;    // append one element at index count
    kind_t            load_kind;
    logic [7:0]       load_byte;
    logic             data_en;    // advance the marks by one data byte
    logic [7:0]       data_byte;  // data byte, case-folded when fold_en is set
    logic             fold_en;    // fold upper case before comparing
    logic             restart;    // marks restart with only position zero set
    logic [CNT_W-1:0] count;      // number of stored elements
  } gwm_ctrl_t;

  // Fold ASCII upper case to lower case when enabled.
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] res;
    res = c;
    if (en && (c >= UPPER_FIRST) && (c <= UPPER_LAST)) begin
      res = c + CASE_OFFSET;
    end
    return res;
  endfunction

endpackage

// ===== rtl/gwm_cell.sv =====
module gwm_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [gwm_pkg::CNT_W-1:0] cell_idx,
  input  gwm_pkg::gwm_ctrl_t      ctrl,
  input  logic                    close_in,
  input  logic                    adv_in,
  output logic                    close_out,
  output logic                    adv_out,
  output logic                    hit
);
  import gwm_pkg::*;

  logic       mark_r;
  logic       mark_nxt;
  kind_t      kind_r;
  logic [7:0] byte_r;
  logic       valid;
  logic       closed;
  logic       live;
  logic       is_star;
  logic       byte_eq;

  // Element occupancy and the closed mark of this position.
  assign valid   = (cell_idx < ctrl.count);
  assign closed  = mark_r | close_in;
  assign live    = closed & valid;
  assign is_star = (kind_r == KIND_STAR);
  assign byte_eq = (fold_byte(byte_r, ctrl.fold_en) == ctrl.data_byte);

  // A live star closes into the next position; a live literal or any advances.
  assign close_out = live & is_star;
  assign adv_out   = live & ~is_star & ((kind_r == KIND_ANY) | byte_eq);

  // This position is the end of the pattern and its mark is set.
  assign hit = closed & (cell_idx == ctrl.count);

  // Next mark: restart, or the raw mark after one data byte.
  always_comb begin
    mark_nxt = mark_r;
    if (ctrl.restart) begin
      mark_nxt = (cell_idx == '0);
    end else if (ctrl.data_en) begin
      mark_nxt = adv_in | close_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= (cell_idx == '0);
    end else begin
      mark_r <= mark_nxt;
    end
  end

  // Pattern element storage, written when an element is appended at this index.
  always_ff @(posedge clk) begin
    if (ctrl.load_we && (cell_idx == ctrl.count)) begin
      kind_r <= ctrl.load_kind;
      byte_r <= ctrl.load_byte;
    end
  end

endmodule

// ===== rtl/glob_wildcard_match_unit.sv =====
// Glob matcher: one input item is taken per cycle, back to back, unless a result is stalled.
// An end-of-data transfer gives its result on the next cycle; other items give no result.
// Every data byte updates all pattern positions at once in a row of cells; the star
// closure ripples through the row within that single cycle, which sets the clock period.
// Synchronous active-low reset empties the pattern, clears escape and overflow flags,
// sets case_sensitive to 0 and leaves only mark zero set; element storage is not cleared.
module glob_wildcard_match_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_matched,
  output logic       out_pattern_overflow
);
  import gwm_pkg::*;

  logic             case_sens_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             esc_r;
  logic             esc_nxt;
  logic             ovf_r;
  logic             ovf_nxt;
  logic             mark_last_r;
  logic             mark_last_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_matched_r;
  logic             out_ovf_r;

  logic             in_acc;
  opcode_t          op;
  logic             full;
  logic             store_req;
  kind_t            new_kind;
  gwm_ctrl_t        ctrl;
  logic             closed_last;
  logic             match_now;

  logic [PATTERN_MAX:0]   close_c;
  logic [PATTERN_MAX:0]   adv_c;
  logic [PATTERN_MAX-1:0] hits;

  assign in_acc = in_valid & ~in_stall;
  assign op     = opcode_t'(in_opcode);
  assign full   = (count_r == CNT_W'(PATTERN_MAX));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_sens_r <= 1'b0;
    end else if (cfg_we) begin
      case_sens_r <= cfg_wdata;
    end
  end

  // Pattern loading: escape handling and element kind.
  always_comb begin
    store_req = 1'b0;
    esc_nxt   = esc_r;
    new_kind  = KIND_LIT;
    if (in_acc && (op == OP_PAT)) begin
      if (esc_r) begin
        esc_nxt   = 1'b0;
        store_req = 1'b1;
      end else if (in_byte_value == CHAR_BACKSLASH) begin
        esc_nxt = 1'b1;
      end else begin
        store_req = 1'b1;
        if (in_byte_value == CHAR_STAR) begin
          new_kind = KIND_STAR;
        end else if (in_byte_value == CHAR_QUESTION) begin
          new_kind = KIND_ANY;
        end
      end
    end else if (in_acc && (op == OP_CLEAR)) begin
      esc_nxt = 1'b0;
    end
  end

  // Element count and overflow flag.
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (in_acc && (op == OP_CLEAR)) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (store_req) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  // Control broadcast to the cell row.
  always_comb begin
    ctrl.load_we   = store_req & ~full;
    ctrl.load_kind = new_kind;
    ctrl.load_byte = in_byte_value;
    ctrl.data_en   = in_acc & (op == OP_DATA);
    ctrl.fold_en   = ~case_sens_r;
    ctrl.data_byte = fold_byte(in_byte_value, ~case_sens_r);
    ctrl.restart   = in_acc & ((op == OP_CLEAR) || (op == OP_END));
    ctrl.count     = count_r;
  end

  // Row of cells, one per pattern position.
  assign close_c[0] = 1'b0;
  assign adv_c[0]   = 1'b0;

  for (genvar gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
    gwm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (CNT_W'(gi)),
      .ctrl      (ctrl),
      .close_in  (close_c[gi]),
      .adv_in    (adv_c[gi]),
      .close_out (close_c[gi+1]),
      .adv_out   (adv_c[gi+1]),
      .hit       (hits[gi])
    );
  end

  // Mark past the last element, reached only when the row is full.
  assign closed_last = mark_last_r | close_c[PATTERN_MAX];
  assign match_now   = (|hits) | (closed_last & full);

  always_comb begin
    mark_last_nxt = mark_last_r;
    if (ctrl.restart) begin
      mark_last_nxt = 1'b0;
    end else if (ctrl.data_en) begin
      mark_last_nxt = adv_c[PATTERN_MAX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      esc_r       <= 1'b0;
      ovf_r       <= 1'b0;
      mark_last_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      esc_r       <= esc_nxt;
      ovf_r       <= ovf_nxt;
      mark_last_r <= mark_last_nxt;
    end
  end

  // Output register: an end-of-data transfer loads it.
  assign in_stall      = out_valid_r & out_stall;
  assign out_valid_nxt = (in_acc && (op == OP_END)) | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (op == OP_END)) begin
      out_matched_r <= match_now;
      out_ovf_r     <= ovf_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_matched          = out_matched_r;
  assign out_pattern_overflow = out_ovf_r;

`ifndef NO_ASSERTIONS
  // The element count never passes the row length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(PATTERN_MAX))
    else $error("pattern count beyond row length");

  // A clear empties the pattern and drops the overflow flag.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (op == OP_CLEAR)) |=> ((count_r == '0) && !ovf_r && !esc_r))
    else $error("clear did not empty the pattern");

  // A result appears only after an end-of-data transfer.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc && (op == OP_END)))
    else $error("result without end of data");

  // Overflow is raised only while the row is full.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> full)
    else $error("overflow raised with room left");

  // The final mark is clear whenever the row is not full.
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> !mark_last_r)
    else $error("final mark set with row not full");
`endif

endmodule
